@@ design/mfdr_pkg.sv @@
// Shared types and constants for the mesh flooding router with duplicate suppression.
// Used by mesh_flood_dedup_router and its checker; depends on nothing.

package mfdr_pkg;

   // Default sizes
   localparam int SEEN_DEPTH     = 32;
   localparam int LISTENER_SLOTS = 10;

   // Field widths
   localparam int SRC_W     = 16;
   localparam int NONCE_W   = 8;
   localparam int DEST_W    = 16;
   localparam int KIND_W    = 2;
   localparam int HOP_W     = 8;
   localparam int CHANNEL_W = 4;
   localparam int VERDICT_W = 3;
   localparam int ENTRY_W   = SRC_W + NONCE_W;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int LIST_HI_W   = 32;
   localparam int SLOT_W      = 16;
   localparam int SLOT_VEC_W  = 2 * CSR_DATA_W + LIST_HI_W;

   localparam logic [SLOT_W-1:0] EMPTY_SLOT = 16'hFFFF;

   // Register reset values
   localparam logic [HOP_W-1:0]      HOP_LIMIT_RESET = 8'd8;
   localparam logic [CSR_DATA_W-1:0] LIST_RESET      = '1;
   localparam logic [LIST_HI_W-1:0]  LIST_HI_RESET   = '1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HOP_LIMIT = 3'd0,
      CSR_LIST_LOW  = 3'd1,
      CSR_LIST_MID  = 3'd2,
      CSR_LIST_HIGH = 3'd3
   } csr_index_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_P2P       = 2'd0,
      KIND_BROADCAST = 2'd1,
      KIND_OTHER_A   = 2'd2,
      KIND_OTHER_B   = 2'd3
   } kind_type;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_DUPLICATE     = 3'd0,
      VERDICT_DELIVERED     = 3'd1,
      VERDICT_DELIVERED_FWD = 3'd2,
      VERDICT_FORWARDED     = 3'd3,
      VERDICT_HOP_LIMIT     = 3'd4,
      VERDICT_TYPE_DROPPED  = 3'd5
   } verdict_type;

endpackage

@@ design/mesh_flood_dedup_router.sv @@
// Top level of the mesh flooding router: duplicate filter over a ring of seen
// (source, nonce) pairs held in one synchronous memory, plus the routing decision.
// Depends on mfdr_pkg.
//
//  port group | direction | handshake            | payload
//  -----------+-----------+----------------------+----------------------------------
//  req_*      | in        | req_valid/req_stall  | source_id, packet_nonce, dest_id,
//             |           |                      | kind, hop_count
//  rsp_*      | out       | rsp_valid/rsp_stall  | deliver, channel, forward, verdict
//  csr_*      | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// The memory scan reads one ring entry per cycle through its single read port until all
// SEEN_DEPTH entries are read; each read entry is registered and compared, and the decision
// is then made in ST_FINISH. No new item is accepted until the sequencer is back in ST_IDLE.
// Reset is synchronous; it clears the ring's valid bits at once, so no clearing pass
// is needed and an entry never written reads as zero.
// A stalled result is held in the output register; a new item is still accepted and
// scanned, and only its final write-back waits for the output register to free up.

module mesh_flood_dedup_router #(
   parameter int SEEN_DEPTH     = mfdr_pkg::SEEN_DEPTH,
   parameter int LISTENER_SLOTS = mfdr_pkg::LISTENER_SLOTS
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [mfdr_pkg::SRC_W-1:0]          req_source_id,
   input  logic [mfdr_pkg::NONCE_W-1:0]        req_packet_nonce,
   input  logic [mfdr_pkg::DEST_W-1:0]         req_dest_id,
   input  logic [mfdr_pkg::KIND_W-1:0]         req_kind,
   input  logic [mfdr_pkg::HOP_W-1:0]          req_hop_count,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_deliver,
   output logic [mfdr_pkg::CHANNEL_W-1:0]      rsp_channel,
   output logic                                rsp_forward,
   output logic [mfdr_pkg::VERDICT_W-1:0]      rsp_verdict,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mfdr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mfdr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int AW = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
   localparam int CW = $clog2(SEEN_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Configuration registers
   logic [mfdr_pkg::HOP_W-1:0]      hop_limit_ff;
   logic [mfdr_pkg::CSR_DATA_W-1:0] list_low_ff;
   logic [mfdr_pkg::CSR_DATA_W-1:0] list_mid_ff;
   logic [mfdr_pkg::LIST_HI_W-1:0]  list_high_ff;

   // Ring memory and its valid bits
   logic [mfdr_pkg::ENTRY_W-1:0] seen_mem [SEEN_DEPTH];
   logic [SEEN_DEPTH-1:0]        seen_vld_ff;
   logic [mfdr_pkg::ENTRY_W-1:0] rd_data_ff;
   logic                         rd_vld_ff;
   logic                         rd_live_ff;

   // Sequencer and captured item
   state_type                    state_ff;
   logic [CW-1:0]                scan_cnt_ff;
   logic [AW-1:0]                ring_ptr_ff;
   logic                         seen_ff;
   logic [mfdr_pkg::ENTRY_W-1:0] key_ff;
   logic [mfdr_pkg::DEST_W-1:0]  dest_ff;
   logic [mfdr_pkg::KIND_W-1:0]  kind_ff;
   logic [mfdr_pkg::HOP_W-1:0]   hops_ff;

   // Output register
   logic                            rsp_valid_ff;
   logic                            rsp_deliver_ff;
   logic [mfdr_pkg::CHANNEL_W-1:0]  rsp_channel_ff;
   logic                            rsp_forward_ff;
   logic [mfdr_pkg::VERDICT_W-1:0]  rsp_verdict_ff;

   // Combinational next values
   logic                            scan_rd_in;
   logic [AW-1:0]                   scan_addr_in;
   logic                            hit_in;
   logic                            out_free_in;
   logic                            finish_in;
   logic                            write_in;
   logic [AW-1:0]                   ring_ptr_in;
   logic [mfdr_pkg::SLOT_VEC_W-1:0] slots_in;
   logic                            match_in;
   logic [mfdr_pkg::CHANNEL_W-1:0]  chan_in;
   logic                            under_in;
   logic                            deliver_in;
   logic [mfdr_pkg::CHANNEL_W-1:0]  channel_in;
   logic                            forward_in;
   mfdr_pkg::verdict_type           verdict_in;

   assign req_stall   = (state_ff != ST_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_deliver = rsp_deliver_ff;
   assign rsp_channel = rsp_channel_ff;
   assign rsp_forward = rsp_forward_ff;
   assign rsp_verdict = rsp_verdict_ff;

   // Take configuration writes; ignore unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         hop_limit_ff <= mfdr_pkg::HOP_LIMIT_RESET;
         list_low_ff  <= mfdr_pkg::LIST_RESET;
         list_mid_ff  <= mfdr_pkg::LIST_RESET;
         list_high_ff <= mfdr_pkg::LIST_HI_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mfdr_pkg::CSR_HOP_LIMIT: hop_limit_ff <= csr_wdata[mfdr_pkg::HOP_W-1:0];
            mfdr_pkg::CSR_LIST_LOW:  list_low_ff  <= csr_wdata;
            mfdr_pkg::CSR_LIST_MID:  list_mid_ff  <= csr_wdata;
            mfdr_pkg::CSR_LIST_HIGH: list_high_ff <= csr_wdata[mfdr_pkg::LIST_HI_W-1:0];
            default: ;
         endcase
      end
   end

   // Scan control: one read per cycle, then compare the registered entry
   assign scan_rd_in   = (state_ff == ST_SCAN) && (scan_cnt_ff < CW'(SEEN_DEPTH));
   assign scan_addr_in = scan_cnt_ff[AW-1:0];
   assign hit_in       = rd_live_ff &&
                         ((rd_vld_ff ? rd_data_ff : '0) == key_ff);

   assign out_free_in = !rsp_valid_ff || !rsp_stall;
   assign finish_in   = (state_ff == ST_FINISH) && out_free_in;
   assign write_in    = finish_in && !seen_ff;
   assign ring_ptr_in = (ring_ptr_ff == AW'(SEEN_DEPTH - 1)) ? '0 : ring_ptr_ff + 1'b1;

   // Write the new pair back at the ring pointer
   always_ff @(posedge clock) begin
      if (write_in) begin
         seen_mem[ring_ptr_ff] <= key_ff;
      end
   end

   // Read one ring entry; data is registered
   always_ff @(posedge clock) begin
      if (scan_rd_in) begin
         rd_data_ff <= seen_mem[scan_addr_in];
      end
   end

   // Valid bits: clear at reset, set on write, read alongside the memory
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_vld_ff <= '0;
         rd_vld_ff   <= 1'b0;
         rd_live_ff  <= 1'b0;
      end else begin
         if (write_in) begin
            seen_vld_ff[ring_ptr_ff] <= 1'b1;
         end
         rd_vld_ff  <= seen_vld_ff[scan_addr_in];
         rd_live_ff <= scan_rd_in;
      end
   end

   // Find the lowest listener slot that matches the destination
   always_comb begin
      slots_in = {list_high_ff, list_mid_ff, list_low_ff};
      match_in = 1'b0;
      chan_in  = '0;
      for (int i = LISTENER_SLOTS - 1; i >= 0; i--) begin
         if (slots_in[i*mfdr_pkg::SLOT_W +: mfdr_pkg::SLOT_W] != mfdr_pkg::EMPTY_SLOT &&
             slots_in[i*mfdr_pkg::SLOT_W +: mfdr_pkg::SLOT_W] == dest_ff) begin
            match_in = 1'b1;
            chan_in  = mfdr_pkg::CHANNEL_W'(i);
         end
      end
   end

   // Routing decision
   always_comb begin
      under_in   = (hops_ff < hop_limit_ff);
      deliver_in = 1'b0;
      channel_in = '0;
      forward_in = 1'b0;
      verdict_in = mfdr_pkg::VERDICT_DUPLICATE;
      priority if (seen_ff) begin
         verdict_in = mfdr_pkg::VERDICT_DUPLICATE;
      end else if (match_in) begin
         deliver_in = 1'b1;
         channel_in = chan_in;
         if (kind_ff == mfdr_pkg::KIND_BROADCAST && under_in) begin
            forward_in = 1'b1;
            verdict_in = mfdr_pkg::VERDICT_DELIVERED_FWD;
         end else begin
            verdict_in = mfdr_pkg::VERDICT_DELIVERED;
         end
      end else if (!under_in) begin
         verdict_in = mfdr_pkg::VERDICT_HOP_LIMIT;
      end else if (kind_ff == mfdr_pkg::KIND_P2P || kind_ff == mfdr_pkg::KIND_BROADCAST) begin
         forward_in = 1'b1;
         verdict_in = mfdr_pkg::VERDICT_FORWARDED;
      end else begin
         verdict_in = mfdr_pkg::VERDICT_TYPE_DROPPED;
      end
   end

   // Sequencer, captured item and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_cnt_ff  <= '0;
         ring_ptr_ff  <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop the result once taken, unless a new one replaces it
         if (rsp_valid_ff && !rsp_stall && !finish_in) begin
            rsp_valid_ff <= 1'b0;
         end

         // Accumulate hits while the scan runs
         if (hit_in) begin
            seen_ff <= 1'b1;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  key_ff      <= {req_source_id, req_packet_nonce};
                  dest_ff     <= req_dest_id;
                  kind_ff     <= req_kind;
                  hops_ff     <= req_hop_count;
                  seen_ff     <= 1'b0;
                  scan_cnt_ff <= '0;
                  state_ff    <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               // Advance the read address; leave after the last compare
               if (scan_rd_in) begin
                  scan_cnt_ff <= scan_cnt_ff + 1'b1;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               // Hold until the output register can take the result
               if (out_free_in) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_deliver_ff <= deliver_in;
                  rsp_channel_ff <= channel_in;
                  rsp_forward_ff <= forward_in;
                  rsp_verdict_ff <= verdict_in;
                  if (!seen_ff) begin
                     ring_ptr_ff <= ring_ptr_in;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

@@ design/mfdr_checker.sv @@
// Port-level checks for mesh_flood_dedup_router, attached with a bind statement.
// Depends on mfdr_pkg and the top level's port list.

module mfdr_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic                               rsp_deliver,
   input logic [mfdr_pkg::CHANNEL_W-1:0]     rsp_channel,
   input logic                               rsp_forward,
   input logic [mfdr_pkg::VERDICT_W-1:0]     rsp_verdict
);

   // No result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A duplicate goes nowhere
   a_dup_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict == mfdr_pkg::VERDICT_DUPLICATE |->
         !rsp_deliver && !rsp_forward && rsp_channel == '0)
      else $error("duplicate item routed");

   // Channel is zero unless delivered
   a_channel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_deliver |-> rsp_channel == '0)
      else $error("channel set without delivery");

   // Forwarding only under the two forwarding verdicts
   a_forward_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_forward |->
         rsp_verdict == mfdr_pkg::VERDICT_DELIVERED_FWD ||
         rsp_verdict == mfdr_pkg::VERDICT_FORWARDED)
      else $error("forward flag with wrong verdict");

   // A stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_verdict) && $stable(rsp_channel))
      else $error("stalled result changed");

endmodule

bind mesh_flood_dedup_router mfdr_checker u_mfdr_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_deliver (rsp_deliver),
   .rsp_channel (rsp_channel),
   .rsp_forward (rsp_forward),
   .rsp_verdict (rsp_verdict)
);
